### rtl/core/skf_pkg.sv
package skf_pkg;

  localparam int IO_W       = 32;
  localparam int CFG_ADDR_W = 2;
  localparam int CFG_DATA_W = 32;
  localparam int NOISE_W    = 32;
  localparam int TS_W       = 16;
  localparam int QUOT_W     = 16;
  localparam int GAIN_W     = QUOT_W + 1;

  localparam logic [CFG_ADDR_W-1:0] REG_PROCESS_NOISE     = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_MEASUREMENT_NOISE = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_TIME_STEP         = 2'd2;

  localparam logic [NOISE_W-1:0] PROCESS_NOISE_RST     = 32'd655;
  localparam logic [NOISE_W-1:0] MEASUREMENT_NOISE_RST = 32'd65536;
  localparam logic [TS_W-1:0]    TIME_STEP_RST         = 16'd328;

  localparam logic [GAIN_W-1:0] GAIN_ONE = 17'h10000;

  typedef struct packed {
    logic signed [IO_W-1:0] measurement;
    logic signed [IO_W-1:0] acceleration;
  } in_item_t;

  typedef struct packed {
    logic signed [IO_W-1:0] estimate;
  } out_item_t;

  typedef struct packed {
    logic              done;
    logic [QUOT_W-1:0] quot;
  } div_stat_t;

endpackage

### rtl/core/skf_stream_if.sv
interface skf_stream_if #(
  parameter type data_t = logic [31:0]
);
  logic  valid;
  logic  ready;
  data_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

### rtl/core/skf_mul.sv
module skf_mul #(
  parameter int A_W = 34
) (
  input  logic                            clk,
  input  logic signed [A_W-1:0]           a,
  input  logic [skf_pkg::GAIN_W-1:0]      g,
  output logic signed [A_W-1:0]           res
);
  import skf_pkg::*;

  localparam int P_W = A_W + GAIN_W + 1;

  logic signed [P_W-1:0] prod;
  logic signed [A_W-1:0] res_r;

  // floor(a * g / 2^16)
  assign prod = P_W'(a) * $signed({1'b0, g});

  always_ff @(posedge clk) begin
    res_r <= prod[A_W+QUOT_W-1:QUOT_W];
  end

  assign res = res_r;
endmodule

### rtl/core/skf_div.sv
module skf_div #(
  parameter int WIDTH = 34
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [WIDTH-1:0]           dividend,
  input  logic [WIDTH-1:0]           divisor,
  output skf_pkg::div_stat_t         status
);
  import skf_pkg::*;

  localparam int CNT_W = $clog2(QUOT_W + 1);

  logic [WIDTH:0]      rem_r, rem_nxt;
  logic [WIDTH-1:0]    d_r;
  logic [QUOT_W-1:0]   q_r, q_nxt;
  logic [CNT_W-1:0]    cnt_r;
  logic [WIDTH:0]      shifted;

  // one restoring step: shift, trial subtract, keep on success
  always_comb begin
    shifted = {rem_r[WIDTH-1:0], 1'b0};
    if (shifted >= {1'b0, d_r}) begin
      rem_nxt = shifted - {1'b0, d_r};
      q_nxt   = {q_r[QUOT_W-2:0], 1'b1};
    end else begin
      rem_nxt = shifted;
      q_nxt   = {q_r[QUOT_W-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (start) begin
      cnt_r <= CNT_W'(QUOT_W);
    end else if (cnt_r != '0) begin
      cnt_r <= cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= {1'b0, dividend};
      d_r   <= divisor;
      q_r   <= '0;
    end else if (cnt_r != '0) begin
      rem_r <= rem_nxt;
      q_r   <= q_nxt;
    end
  end

  assign status.done = (cnt_r == '0);
  assign status.quot = q_r;
endmodule

### rtl/core/scalar_kalman_filter.sv
// Scalar Kalman filter, signed fixed point.
// Input channel in_ch carries a request of measurement and acceleration;
// output channel out_ch returns the updated estimate, one per request.
// Both use valid/ready; a transfer happens when both are high.
// The cfg port writes process_noise (0), measurement_noise (1) and
// time_step (2); other indexes are ignored. Write only idle.
// One shared multiplier serves the prediction, correction and covariance
// products; the gain comes from a 16-step restoring divider at one quotient
// bit per cycle, or is 1.0 when measurement_noise is 0.
// in_ch.ready is high only while the sequencer is idle, so a new request
// starts once the previous one has moved into the output register.
// The output register holds a result until taken; if the receiver stalls,
// the next result waits in the final step until the register frees up.
// Reset (rst_n low, synchronous) restores the register defaults, the
// estimate to 0 and the covariance to 100.0, and drops any pending result.
module scalar_kalman_filter #(
  parameter int DATA_WIDTH = 32,
  parameter int FRAC_BITS  = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  skf_stream_if.sink                          in_ch,
  skf_stream_if.source                        out_ch,
  input  logic                                cfg_we,
  input  logic [skf_pkg::CFG_ADDR_W-1:0]      cfg_addr,
  input  logic [skf_pkg::CFG_DATA_W-1:0]      cfg_wdata
);
  import skf_pkg::*;

  localparam int EW = (DATA_WIDTH > IO_W) ? DATA_WIDTH : IO_W;
  localparam int MW = EW + 2;
  localparam int CW = DATA_WIDTH + 1;
  localparam int SW = ((CW > NOISE_W) ? CW : NOISE_W) + 1;
  localparam logic [CW-1:0] COV_RST = CW'(64'd100 << FRAC_BITS);

  typedef enum logic [7:0] {
    S_IDLE     = 8'b0000_0001,
    S_PRED_MUL = 8'b0000_0010,
    S_PRED     = 8'b0000_0100,
    S_DIV      = 8'b0000_1000,
    S_CORR_MUL = 8'b0001_0000,
    S_CORR     = 8'b0010_0000,
    S_COV      = 8'b0100_0000,
    S_OUT      = 8'b1000_0000
  } state_t;

  state_t state_r, state_nxt;

  logic [NOISE_W-1:0]           q_r, r_r;
  logic [TS_W-1:0]              ts_r;
  logic signed [DATA_WIDTH-1:0] est_r, x_r;
  logic [CW-1:0]                cov_r, p_r;
  logic signed [IO_W-1:0]       meas_r, accel_r;
  logic [GAIN_W-1:0]            gain_r;
  logic                         out_valid_r;
  out_item_t                    out_data_r;

  logic signed [MW-1:0]         mul_a, mul_res;
  logic [GAIN_W-1:0]            mul_g;
  logic                         div_start;
  div_stat_t                    div_stat;
  logic [SW-1:0]                cov_sum, div_d;
  logic signed [MW:0]           est_sum;
  logic signed [DATA_WIDTH-1:0] est_sat;
  logic signed [EW-1:0]         x_ext;
  logic                         fits;

  function automatic logic signed [DATA_WIDTH-1:0] sat_est(input logic signed [MW:0] v);
    logic ok;
    ok = (v[MW:DATA_WIDTH-1] == '0) || (v[MW:DATA_WIDTH-1] == '1);
    if (ok) begin
      return v[DATA_WIDTH-1:0];
    end else if (v[MW]) begin
      return {1'b1, {(DATA_WIDTH-1){1'b0}}};
    end else begin
      return {1'b0, {(DATA_WIDTH-1){1'b1}}};
    end
  endfunction

  skf_mul #(.A_W(MW)) u_mul (
    .clk (clk),
    .a   (mul_a),
    .g   (mul_g),
    .res (mul_res)
  );

  skf_div #(.WIDTH(SW)) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (SW'(p_r)),
    .divisor  (div_d),
    .status   (div_stat)
  );

  // shared multiplier operand select
  always_comb begin
    mul_a = MW'(accel_r);
    mul_g = {1'b0, ts_r};
    case (state_r)
      S_CORR_MUL: begin
        mul_a = MW'(meas_r) - MW'(x_r);
        mul_g = gain_r;
      end
      S_CORR: begin
        mul_a = MW'(p_r);
        mul_g = GAIN_ONE - gain_r;
      end
      default: begin
        mul_a = MW'(accel_r);
        mul_g = {1'b0, ts_r};
      end
    endcase
  end

  assign cov_sum   = SW'(cov_r) + SW'(q_r);
  assign fits      = (cov_sum[SW-1:CW] == '0);
  assign div_d     = SW'(p_r) + SW'(r_r);
  assign div_start = (state_r == S_PRED);
  assign est_sum   = (MW+1)'(x_r) + (MW+1)'(mul_res);
  assign est_sat   = sat_est(est_sum);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:     if (in_ch.valid) state_nxt = S_PRED_MUL;
      S_PRED_MUL: state_nxt = S_PRED;
      S_PRED:     state_nxt = S_DIV;
      S_DIV:      if (div_stat.done) state_nxt = S_CORR_MUL;
      S_CORR_MUL: state_nxt = S_CORR;
      S_CORR:     state_nxt = S_COV;
      S_COV:      state_nxt = S_OUT;
      S_OUT:      if (!out_valid_r || out_ch.ready) state_nxt = S_IDLE;
      default:    state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_r  <= PROCESS_NOISE_RST;
      r_r  <= MEASUREMENT_NOISE_RST;
      ts_r <= TIME_STEP_RST;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_PROCESS_NOISE:     q_r  <= cfg_wdata[NOISE_W-1:0];
        REG_MEASUREMENT_NOISE: r_r  <= cfg_wdata[NOISE_W-1:0];
        REG_TIME_STEP:         ts_r <= cfg_wdata[TS_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      est_r <= '0;
      cov_r <= COV_RST;
    end else if (state_r == S_OUT && state_nxt == S_IDLE) begin
      est_r <= x_r;
      cov_r <= p_r;
    end
  end

  always_ff @(posedge clk) begin
    unique case (state_r)
      S_IDLE: begin
        meas_r  <= in_ch.data.measurement;
        accel_r <= in_ch.data.acceleration;
        x_r     <= est_r;
      end
      S_PRED_MUL: begin
        p_r <= fits ? cov_sum[CW-1:0] : '1;
      end
      S_PRED: begin
        x_r <= est_sat;
      end
      S_DIV: begin
        gain_r <= (r_r == '0) ? GAIN_ONE : {1'b0, div_stat.quot};
      end
      S_CORR: begin
        x_r <= est_sat;
      end
      S_COV: begin
        p_r <= mul_res[CW-1:0];
      end
      default: ;
    endcase
  end

  assign x_ext = EW'(x_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == S_OUT && state_nxt == S_IDLE) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_OUT && state_nxt == S_IDLE) begin
      out_data_r.estimate <= x_ext[IO_W-1:0];
    end
  end

  assign in_ch.ready  = (state_r == S_IDLE);
  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = out_data_r;
endmodule

### dv/skf_checker.sv
`timescale 1ns / 1ps

module skf_checker
  import skf_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  logic                  in_ready,
  input  in_item_t              in_data,
  input  logic                  out_valid,
  input  logic                  out_ready,
  input  out_item_t             out_data,
  input  logic                  cfg_we,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  output int unsigned           mismatches,
  output int unsigned           outstanding
);

  localparam logic [63:0]        COV_MAX = 64'h1_FFFF_FFFF;
  localparam logic [IO_W:0]      COV_RST = 33'd6553600;
  localparam logic signed [63:0] EST_HI  = 64'sh7FFF_FFFF;
  localparam logic signed [63:0] EST_LO  = -64'sh8000_0000;
  localparam int                 PRINT_CAP = 200;

  logic [NOISE_W-1:0]     q_noise;
  logic [NOISE_W-1:0]     r_noise;
  logic [TS_W-1:0]        dt;
  logic signed [IO_W-1:0] est_state;
  logic [IO_W:0]          cov_state;
  logic signed [IO_W-1:0] estimate_q[$];

  function automatic logic signed [63:0] mul_frac(input logic signed [63:0] a,
                                                  input logic [GAIN_W-1:0] g);
    logic signed [81:0] prod;
    prod = a * $signed({1'b0, g});
    return 64'(prod >>> 16);
  endfunction

  function automatic logic signed [63:0] clamp_est(input logic signed [63:0] v);
    if (v > EST_HI) return EST_HI;
    if (v < EST_LO) return EST_LO;
    return v;
  endfunction

  function automatic logic signed [IO_W-1:0] filter_step(input in_item_t req);
    logic signed [63:0] x;
    logic signed [63:0] meas;
    logic [63:0]        p;
    logic [63:0]        d;
    logic [63:0]        rem;
    logic [GAIN_W-1:0]  gain;
    meas = $signed(req.measurement);
    x = clamp_est(est_state + mul_frac($signed(req.acceleration), {1'b0, dt}));
    p = 64'(cov_state) + 64'(q_noise);
    if (p > COV_MAX) p = COV_MAX;
    d = p + 64'(r_noise);
    if (r_noise == '0) begin
      gain = GAIN_ONE;
    end else begin
      rem = p;
      gain = '0;
      for (int i = 0; i < QUOT_W; i++) begin
        rem = rem << 1;
        gain = gain << 1;
        if (rem >= d) begin
          rem = rem - d;
          gain[0] = 1'b1;
        end
      end
    end
    x = clamp_est(x + mul_frac(meas - x, gain));
    p = mul_frac($signed(p), GAIN_ONE - gain);
    if (p > COV_MAX) p = COV_MAX;
    est_state = x[IO_W-1:0];
    cov_state = p[IO_W:0];
    return x[IO_W-1:0];
  endfunction

  task automatic report_mismatch(input string msg);
    if (mismatches < PRINT_CAP) $display("%0t: %s", $time, msg);
    mismatches++;
  endtask

  always @(posedge clk) begin : watch
    logic signed [IO_W-1:0] want;
    if (!rst_n) begin
      q_noise   = PROCESS_NOISE_RST;
      r_noise   = MEASUREMENT_NOISE_RST;
      dt        = TIME_STEP_RST;
      est_state = '0;
      cov_state = COV_RST;
      estimate_q.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (estimate_q.size() == 0) begin
          report_mismatch($sformatf("estimate %0d with no request outstanding",
                                    $signed(out_data.estimate)));
        end else begin
          want = estimate_q.pop_front();
          if (out_data.estimate !== want)
            report_mismatch($sformatf("estimate expected %0d got %0d",
                                      want, $signed(out_data.estimate)));
        end
      end
      if (in_valid && in_ready) estimate_q.push_back(filter_step(in_data));
      if (cfg_we) begin
        case (cfg_addr)
          REG_PROCESS_NOISE:     q_noise = cfg_wdata[NOISE_W-1:0];
          REG_MEASUREMENT_NOISE: r_noise = cfg_wdata[NOISE_W-1:0];
          REG_TIME_STEP:         dt = cfg_wdata[TS_W-1:0];
          default: ;
        endcase
      end
    end
    outstanding = estimate_q.size();
  end

endmodule

### dv/scalar_kalman_filter_tb.sv
`timescale 1ns / 1ps

module scalar_kalman_filter_tb;
  import skf_pkg::*;

  localparam logic [CFG_ADDR_W-1:0] REG_UNUSED = 2'd3;
  localparam int                    PHASES      = 10;
  localparam int                    PHASE_ITEMS = 120;
  localparam int                    HOLD_CYCLES = 300;
  localparam logic signed [IO_W-1:0] S_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [IO_W-1:0] S_MIN = 32'sh8000_0000;

  logic                   clk;
  logic                   rst_n;
  logic                   cfg_we;
  logic [CFG_ADDR_W-1:0]  cfg_addr;
  logic [CFG_DATA_W-1:0]  cfg_wdata;
  int unsigned            mismatches;
  int unsigned            outstanding;
  int                     sink_hold;
  bit                     sink_busy;
  logic signed [IO_W-1:0] track;

  skf_stream_if #(.data_t(in_item_t))  req_if ();
  skf_stream_if #(.data_t(out_item_t)) est_if ();

  scalar_kalman_filter uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (req_if),
    .out_ch    (est_if),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata)
  );

  skf_checker chk (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (req_if.valid),
    .in_ready    (req_if.ready),
    .in_data     (req_if.data),
    .out_valid   (est_if.valid),
    .out_ready   (est_if.ready),
    .out_data    (est_if.data),
    .cfg_we      (cfg_we),
    .cfg_addr    (cfg_addr),
    .cfg_wdata   (cfg_wdata),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  initial begin
    #5_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  function automatic int draw_gap(input bit busy);
    if (busy || $urandom_range(3, 0) == 0) return 0;
    return $urandom_range(14, 0);
  endfunction

  function automatic logic [NOISE_W-1:0] draw_noise();
    int unsigned pick;
    pick = $urandom_range(3, 0);
    if (pick == 0) return '0;
    if (pick == 1) return $urandom;
    return $urandom_range(1 << 20, 1);
  endfunction

  function automatic in_item_t random_request();
    in_item_t    req;
    int unsigned pick;
    pick = $urandom_range(9, 0);
    if (pick < 4) begin
      req.measurement  = $urandom;
      req.acceleration = $urandom;
    end else if (pick < 9) begin
      req.measurement  = track + $signed($urandom_range(1 << 18, 0)) - (1 << 17);
      req.acceleration = $signed($urandom_range(1 << 20, 0)) - (1 << 19);
    end else begin
      req.measurement  = $urandom_range(1, 0) ? S_MAX : S_MIN;
      req.acceleration = $urandom_range(1, 0) ? S_MAX : S_MIN;
    end
    return req;
  endfunction

  task automatic send_request(input in_item_t req, input int gap);
    if (gap > 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    req_if.valid <= 1'b1;
    req_if.data  <= req;
    do @(posedge clk); while (!req_if.ready);
    @(negedge clk);
  endtask

  task automatic drain();
    req_if.valid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we    <= 1'b0;
    @(negedge clk);
  endtask

  task automatic configure(input logic [NOISE_W-1:0] q, input logic [NOISE_W-1:0] r,
                           input logic [TS_W-1:0] dt);
    write_reg(REG_PROCESS_NOISE, q);
    write_reg(REG_MEASUREMENT_NOISE, r);
    write_reg(REG_TIME_STEP, {16'($urandom), dt});
  endtask

  task automatic run_random(input int count, input bit src_busy);
    for (int n = 0; n < count; n++) begin
      track = track + $signed($urandom_range(1 << 16, 0)) - (1 << 15);
      send_request(random_request(), draw_gap(src_busy));
      if ($urandom_range(39, 0) == 0) drain();
    end
  endtask

  initial begin : result_sink
    int wait_cycles;
    wait_cycles  = 0;
    est_if.ready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (sink_hold > 0) begin
        est_if.ready <= 1'b0;
        sink_hold--;
      end else if (wait_cycles > 0) begin
        est_if.ready <= 1'b0;
        wait_cycles--;
      end else begin
        est_if.ready <= 1'b1;
        @(posedge clk);
        if (est_if.valid) wait_cycles = draw_gap(sink_busy);
      end
    end
  end

  initial begin : stimulus
    in_item_t directed [14];
    rst_n        = 1'b0;
    cfg_we       = 1'b0;
    cfg_addr     = '0;
    cfg_wdata    = '0;
    req_if.valid = 1'b0;
    req_if.data  = '0;
    sink_hold    = 0;
    sink_busy    = 1'b0;
    track        = '0;
    directed = '{
      '{32'sd0, 32'sd0}, '{S_MAX, 32'sd0}, '{S_MIN, 32'sd0}, '{32'sd0, S_MAX},
      '{32'sd0, S_MIN}, '{S_MAX, S_MAX}, '{S_MAX, S_MAX}, '{S_MIN, S_MIN},
      '{S_MIN, S_MIN}, '{32'shAAAA_AAAA, 32'sh5555_5555},
      '{32'sh5555_5555, 32'shAAAA_AAAA}, '{-32'sd1, -32'sd1}, '{32'sd1, 32'sd1},
      '{32'sh0001_0000, 32'shFFFF_0000}
    };

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    write_reg(REG_UNUSED, $urandom);
    foreach (directed[k]) send_request(directed[k], draw_gap(1'b0));
    run_random(PHASE_ITEMS - 14, 1'b0);
    drain();

    for (int ph = 1; ph < PHASES; ph++) begin
      case (ph)
        1:       configure('0, '0, '1);
        2:       configure('1, '1, '0);
        3:       configure('0, '1, '1);
        4:       configure('1, '0, 16'd1);
        default: configure(draw_noise(), draw_noise(), 16'($urandom));
      endcase
      sink_busy = (ph % 4 == 3);
      if (ph == 1) sink_hold = HOLD_CYCLES;
      run_random(PHASE_ITEMS, ph == 1 || ph % 3 == 2);
      drain();
    end

    repeat (40) @(negedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

### filelist.f
rtl/core/skf_pkg.sv
rtl/core/skf_stream_if.sv
rtl/core/skf_mul.sv
rtl/core/skf_div.sv
rtl/core/scalar_kalman_filter.sv
dv/skf_checker.sv
dv/scalar_kalman_filter_tb.sv
